// ----- hdl/rolling_zscore_pair_signal_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rolling z-score pair signal block.
// Each macro expands to one labeled concurrent assertion on clk that is
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROLLING_ZSCORE_PAIR_SIGNAL_MACROS_SVH
`define ROLLING_ZSCORE_PAIR_SIGNAL_MACROS_SVH

// Same-cycle implication.
`define RZPS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RZPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rzps_pkg.sv -----
// ----------------------------------------------------------------------------
// rzps_pkg
// Shared constants, codes and types of the rolling z-score pair signal block.
// ----------------------------------------------------------------------------
package rzps_pkg;

	// Window length and derived index widths.
	localparam int WINDOW = 8;
	localparam int IDX_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);

	// Data widths.
	localparam int PRICE_W  = 24;
	localparam int SPREAD_W = PRICE_W + 1;
	localparam int SMAG_W   = SPREAD_W - 1;
	localparam int SQR_W    = 2 * SMAG_W;
	localparam int SUM_W    = 34;
	localparam int SQ_W     = 57;
	localparam int D_W      = SUM_W + 2;
	localparam int MULB_W   = D_W - 1;
	localparam int V_W      = SQ_W + CNT_W;
	localparam int PROD_W   = V_W + MULB_W;
	localparam int MCNT_W   = $clog2(MULB_W + 1);
	localparam int THR_W    = 16;
	localparam int TSQ_W    = 2 * THR_W;
	localparam int ZFRAC_W  = 2 * (THR_W / 2);
	localparam int SIG_W    = 2;

	// Output codes.
	localparam logic [SIG_W-1:0] SIG_LONG  = 2'd0;
	localparam logic [SIG_W-1:0] SIG_SHORT = 2'd1;
	localparam logic [SIG_W-1:0] SIG_CLOSE = 2'd2;
	localparam logic [SIG_W-1:0] SIG_NONE  = 2'd3;

	// Configuration port.
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_EXIT  = 1'b1;
	localparam logic [THR_W-1:0] ENTRY_RESET = 16'd256;
	localparam logic [THR_W-1:0] EXIT_RESET  = 16'd205;

	typedef struct packed {
		logic [THR_W-1:0] entry_threshold;
		logic [THR_W-1:0] exit_threshold;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [V_W-1:0]    a;
		logic [MULB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] p;
	} mul_rsp_t;

endpackage

// ----- hdl/rzps_if.sv -----
// ----------------------------------------------------------------------------
// rzps_if
// Valid/ready channels for price beats in and signal beats out.
// ----------------------------------------------------------------------------
interface rzps_in_if;
	logic                         valid;
	logic                         ready;
	logic [rzps_pkg::PRICE_W-1:0] price_a;
	logic [rzps_pkg::PRICE_W-1:0] price_b;

	modport source (output valid, output price_a, output price_b, input ready);
	modport sink (input valid, input price_a, input price_b, output ready);
endinterface

interface rzps_out_if;
	logic                       valid;
	logic                       ready;
	logic [rzps_pkg::SIG_W-1:0] signal;

	modport source (output valid, output signal, input ready);
	modport sink (input valid, input signal, output ready);
endinterface

// ----- hdl/rzps_ram.sv -----
// ----------------------------------------------------------------------------
// rzps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rzps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/rzps_mul.sv -----
// ----------------------------------------------------------------------------
// rzps_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rzps_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  rzps_pkg::mul_req_t req,
	output rzps_pkg::mul_rsp_t rsp
);

	logic [rzps_pkg::MCNT_W-1:0] cnt_q;
	logic                        done_q;
	logic [rzps_pkg::PROD_W-1:0] acc_q;
	logic [rzps_pkg::PROD_W-1:0] mc_q;
	logic [rzps_pkg::MULB_W-1:0] mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == rzps_pkg::MCNT_W'(1));
			if (req.start) begin
				cnt_q <= rzps_pkg::MCNT_W'(rzps_pkg::MULB_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mc_q  <= rzps_pkg::PROD_W'(req.a);
			mp_q  <= req.b;
		end else if (cnt_q != '0) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

endmodule

// ----- hdl/rzps_cfg.sv -----
// ----------------------------------------------------------------------------
// rzps_cfg
// APB register file holding the entry and exit thresholds.
// ----------------------------------------------------------------------------
module rzps_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rzps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [rzps_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [rzps_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output rzps_pkg::cfg_t                  cfg
);

	logic [rzps_pkg::THR_W-1:0]     entry_q;
	logic [rzps_pkg::THR_W-1:0]     exit_q;
	logic [rzps_pkg::REG_IDX_W-1:0] idx;
	logic                           wr;

	assign idx    = paddr[rzps_pkg::CFG_ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= rzps_pkg::ENTRY_RESET;
			exit_q  <= rzps_pkg::EXIT_RESET;
		end else if (wr) begin
			case (idx)
				rzps_pkg::REG_ENTRY: begin
					entry_q <= pwdata[rzps_pkg::THR_W-1:0];
				end
				rzps_pkg::REG_EXIT: begin
					exit_q <= pwdata[rzps_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			rzps_pkg::REG_ENTRY: prdata = rzps_pkg::CFG_DATA_W'(entry_q);
			rzps_pkg::REG_EXIT:  prdata = rzps_pkg::CFG_DATA_W'(exit_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.entry_threshold = entry_q;
	assign cfg.exit_threshold  = exit_q;

endmodule

// ----- hdl/rzps_core.sv -----
// ----------------------------------------------------------------------------
// rzps_core
// Spread window in RAM, running sums, and the sequencer that forms the
// exact z-score comparison on the shared multiplier.
// ----------------------------------------------------------------------------
`include "rolling_zscore_pair_signal_macros.svh"

module rzps_core (
	input  logic           clk,
	input  logic           arst_n,
	input  rzps_pkg::cfg_t cfg,
	rzps_in_if.sink        tick,
	rzps_out_if.source     result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MSS  = 3'd2;
	localparam logic [2:0] ST_MDD  = 3'd3;
	localparam logic [2:0] ST_MVE  = 3'd4;
	localparam logic [2:0] ST_MVX  = 3'd5;
	localparam logic [2:0] ST_PUSH = 3'd6;

	localparam logic signed [rzps_pkg::D_W-1:0] WIN_D = rzps_pkg::D_W'(rzps_pkg::WINDOW);

	// Control state.
	logic [2:0]                           state_q;
	logic [rzps_pkg::CNT_W-1:0]           fill_q;
	logic [rzps_pkg::IDX_W-1:0]           ptr_q;
	logic signed [rzps_pkg::SUM_W-1:0]    sum_q;
	logic [rzps_pkg::SQ_W-1:0]            sq_q;
	logic                                 out_valid_q;

	// Per-item working registers.
	logic signed [rzps_pkg::SPREAD_W-1:0] s_q;
	logic signed [rzps_pkg::SPREAD_W-1:0] old_q;
	logic [rzps_pkg::SQR_W-1:0]           sqnew_q;
	logic [rzps_pkg::SQR_W-1:0]           sqold_q;
	logic signed [rzps_pkg::D_W-1:0]      d_q;
	logic [rzps_pkg::V_W-1:0]             wq_q;
	logic [rzps_pkg::V_W-1:0]             v_q;
	logic [rzps_pkg::TSQ_W-1:0]           te_q;
	logic [rzps_pkg::TSQ_W-1:0]           tx_q;
	logic [rzps_pkg::PROD_W-1:0]          lhs_q;
	logic                                 gt_q;
	logic [rzps_pkg::SIG_W-1:0]           sig_q;
	logic [rzps_pkg::SIG_W-1:0]           out_sig_q;

	logic                                 accept;
	logic                                 full;
	logic                                 push_ok;
	logic                                 ram_we;
	logic                                 out_load;
	logic                                 mul_phase;
	logic [rzps_pkg::SPREAD_W-1:0]        rd_spread;
	logic signed [rzps_pkg::D_W-1:0]      s_ext;
	logic signed [rzps_pkg::D_W-1:0]      sum_ext;
	logic [rzps_pkg::SUM_W-1:0]           sabs;
	logic [rzps_pkg::MULB_W-1:0]          dabs;
	logic [rzps_pkg::SMAG_W-1:0]          s_mag;
	logic [rzps_pkg::SMAG_W-1:0]          old_mag;
	logic signed [rzps_pkg::SUM_W-1:0]    s_sum;
	logic signed [rzps_pkg::SUM_W-1:0]    old_sum;
	logic                                 zero_var;
	logic                                 d_pos;
	logic                                 d_neg;
	logic                                 lt_exit;
	logic [rzps_pkg::SIG_W-1:0]           sig_next;
	rzps_pkg::mul_req_t                   mreq;
	rzps_pkg::mul_rsp_t                   mrsp;

	rzps_ram #(
		.WIDTH(rzps_pkg::SPREAD_W),
		.DEPTH(rzps_pkg::WINDOW)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (s_q),
		.raddr (ptr_q),
		.rdata (rd_spread)
	);

	rzps_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign tick.ready = (state_q == ST_IDLE);
	assign accept     = tick.valid && tick.ready;
	assign full       = (fill_q == rzps_pkg::CNT_W'(rzps_pkg::WINDOW));
	assign push_ok    = !full || !out_valid_q || result.ready;
	assign ram_we     = (state_q == ST_PUSH) && push_ok;
	assign out_load   = ram_we && full;
	assign mul_phase  = (state_q == ST_MSS) || (state_q == ST_MDD) ||
		(state_q == ST_MVE) || (state_q == ST_MVX);

	assign s_ext   = {{(rzps_pkg::D_W - rzps_pkg::SPREAD_W){s_q[rzps_pkg::SPREAD_W-1]}}, s_q};
	assign sum_ext = {{(rzps_pkg::D_W - rzps_pkg::SUM_W){sum_q[rzps_pkg::SUM_W-1]}}, sum_q};
	assign sabs    = sum_q[rzps_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign dabs    = rzps_pkg::MULB_W'(d_q[rzps_pkg::D_W-1] ? (~d_q + 1'b1) : d_q);
	assign s_mag   = rzps_pkg::SMAG_W'(s_q[rzps_pkg::SPREAD_W-1] ? (~s_q + 1'b1) : s_q);
	assign old_mag = rzps_pkg::SMAG_W'(rd_spread[rzps_pkg::SPREAD_W-1] ?
		(~rd_spread + 1'b1) : rd_spread);
	assign s_sum   = {{(rzps_pkg::SUM_W - rzps_pkg::SPREAD_W){s_q[rzps_pkg::SPREAD_W-1]}}, s_q};
	assign old_sum = {{(rzps_pkg::SUM_W - rzps_pkg::SPREAD_W){old_q[rzps_pkg::SPREAD_W-1]}},
		old_q};

	// Multiplier schedule: S*S, d*d, V*Te, V*Tx, each started as the last finishes.
	always_comb begin
		mreq.start = 1'b0;
		mreq.a     = '0;
		mreq.b     = '0;
		case (state_q)
			ST_LOAD: begin
				mreq.start = full;
				mreq.a     = rzps_pkg::V_W'(sabs);
				mreq.b     = rzps_pkg::MULB_W'(sabs);
			end
			ST_MSS: begin
				mreq.start = mrsp.done;
				mreq.a     = rzps_pkg::V_W'(dabs);
				mreq.b     = dabs;
			end
			ST_MDD: begin
				mreq.start = mrsp.done;
				mreq.a     = v_q;
				mreq.b     = rzps_pkg::MULB_W'(te_q);
			end
			ST_MVE: begin
				mreq.start = mrsp.done;
				mreq.a     = v_q;
				mreq.b     = rzps_pkg::MULB_W'(tx_q);
			end
			default: begin
			end
		endcase
	end

	// Decision, taken when the last product arrives.
	assign zero_var = (v_q == '0);
	assign d_neg    = d_q[rzps_pkg::D_W-1];
	assign d_pos    = !d_neg && (d_q != '0);
	assign lt_exit  = (lhs_q < mrsp.p);

	always_comb begin
		if (zero_var) begin
			sig_next = d_pos ? rzps_pkg::SIG_LONG :
				(d_neg ? rzps_pkg::SIG_SHORT : rzps_pkg::SIG_NONE);
		end else if (gt_q && d_pos) begin
			sig_next = rzps_pkg::SIG_LONG;
		end else if (gt_q && d_neg) begin
			sig_next = rzps_pkg::SIG_SHORT;
		end else if (lt_exit) begin
			sig_next = rzps_pkg::SIG_CLOSE;
		end else begin
			sig_next = rzps_pkg::SIG_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			ptr_q       <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= full ? ST_MSS : ST_PUSH;
				end
				ST_MSS: begin
					if (mrsp.done) begin
						state_q <= ST_MDD;
					end
				end
				ST_MDD: begin
					if (mrsp.done) begin
						state_q <= ST_MVE;
					end
				end
				ST_MVE: begin
					if (mrsp.done) begin
						state_q <= ST_MVX;
					end
				end
				ST_MVX: begin
					if (mrsp.done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						state_q <= ST_IDLE;
						sum_q   <= sum_q + s_sum - (full ? old_sum : '0);
						sq_q    <= sq_q + rzps_pkg::SQ_W'(sqnew_q) -
							(full ? rzps_pkg::SQ_W'(sqold_q) : '0);
						if (!full) begin
							fill_q <= fill_q + 1'b1;
						end
						if (ptr_q == rzps_pkg::IDX_W'(rzps_pkg::WINDOW - 1)) begin
							ptr_q <= '0;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= rzps_pkg::SPREAD_W'({1'b0, tick.price_a}) -
				rzps_pkg::SPREAD_W'({1'b0, tick.price_b});
		end
		if (state_q == ST_LOAD) begin
			old_q   <= rd_spread;
			sqold_q <= rzps_pkg::SQR_W'(old_mag) * rzps_pkg::SQR_W'(old_mag);
			sqnew_q <= rzps_pkg::SQR_W'(s_mag) * rzps_pkg::SQR_W'(s_mag);
			d_q     <= s_ext * WIN_D - sum_ext;
			wq_q    <= rzps_pkg::V_W'(sq_q) * rzps_pkg::V_W'(rzps_pkg::WINDOW);
			te_q    <= rzps_pkg::TSQ_W'(cfg.entry_threshold) *
				rzps_pkg::TSQ_W'(cfg.entry_threshold);
			tx_q    <= rzps_pkg::TSQ_W'(cfg.exit_threshold) *
				rzps_pkg::TSQ_W'(cfg.exit_threshold);
		end
		if (state_q == ST_MSS && mrsp.done) begin
			v_q <= wq_q - rzps_pkg::V_W'(mrsp.p);
		end
		if (state_q == ST_MDD && mrsp.done) begin
			lhs_q <= mrsp.p << rzps_pkg::ZFRAC_W;
		end
		if (state_q == ST_MVE && mrsp.done) begin
			gt_q <= (lhs_q > mrsp.p);
		end
		if (state_q == ST_MVX && mrsp.done) begin
			sig_q <= sig_next;
		end
		if (out_load) begin
			out_sig_q <= sig_q;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.signal = out_sig_q;

	`RZPS_ASSERT_NEXT(a_accept_to_load, accept, state_q == ST_LOAD, "accept did not start a read")
	`RZPS_ASSERT_IMPL(a_mul_in_sched, mrsp.done, mul_phase, "product outside schedule")
	`RZPS_ASSERT_NEXT(a_sums_only_on_push, !ram_we, $stable({sum_q, sq_q}), "stray sum update")
	`RZPS_ASSERT_IMPL(a_no_result_overwrite, out_load, !out_valid_q || result.ready, "overwrite")

endmodule

// ----- hdl/rolling_zscore_pair_signal.sv -----
// ----------------------------------------------------------------------------
// rolling_zscore_pair_signal
// Pair spread z-score signal over a rolling window, with APB thresholds.
// ----------------------------------------------------------------------------
// Each input beat carries one price of each asset; the block forms the spread
// price_a - price_b and keeps the last WINDOW spreads in a small RAM along with
// their exact running sum and sum of squares. Once the window is full, every
// beat yields one signal beat that compares the z-score of the new spread,
// taken against the earlier window only, with the entry and exit thresholds;
// beats before that produce nothing. The block works on one beat at a time.
// While the window fills, a beat goes through accept, history read and push.
// With a full window the exact comparison needs four wide products (sum
// squared, deviation squared, and the variance times each squared threshold),
// and they all run through one shift-and-add multiplier that retires one bit
// per cycle and hands each product over with a registered done flag. The
// signal waits in an output register, so a new price beat is taken while it
// is still unread; the push stalls only if a second signal would overwrite an
// unread one. The history RAM needs no clearing pass after reset, since no
// slot's content is used before it has been written. Thresholds are to be
// written over APB only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module rolling_zscore_pair_signal (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rzps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [rzps_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [rzps_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	rzps_in_if.sink                         tick,
	rzps_out_if.source                      result
);

	// Threshold registers as seen by the datapath.
	rzps_pkg::cfg_t cfg;

	rzps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Window storage, running sums, multiplier schedule and the output register.
	rzps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tick   (tick),
		.result (result)
	);

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the rolling z-score pair signal block against a cycle-free predictor.
// A short table of price beats walks the block through its fill phase and the
// corner cases of the z-score compare. Random phases follow, each with its own
// thresholds written over APB. Every signal beat is compared with the oldest
// prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rzps_pkg::*;

	// One full-window beat runs four serial products of MULB_W bits each,
	// and every product then has to be handed over.
	localparam int BEAT_CYCLES     = 4 * (MULB_W + 1) + 3;
	localparam int PHASES          = 10;
	localparam int TICKS_PER_PHASE = 183;
	localparam int CALM_TICKS      = 150;
	localparam int DIRECTED_ROWS   = 23;

	localparam logic [PRICE_W-1:0] PRICE_MAX   = '1;
	localparam longint             SPREAD_PEAK = (longint'(1) << PRICE_W) - 1;

	typedef enum logic [1:0] {ROW_QUIET, ROW_TYPED, ROW_PREDICT} row_kind_t;
	typedef enum logic [1:0] {SHAPE_FLAT, SHAPE_JITTER, SHAPE_SWING, SHAPE_RAW} spread_shape_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price_a;
		logic [PRICE_W-1:0] price_b;
		row_kind_t          kind;
		logic [SIG_W-1:0]   signal;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	rzps_in_if  tick_if();
	rzps_out_if result_if();

	rolling_zscore_pair_signal dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tick    (tick_if),
		.result  (result_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the spread window, its exact sums and the thresholds.
	logic signed [SPREAD_W-1:0] held_spreads [WINDOW];
	logic signed [SUM_W-1:0]    spread_sum;
	logic [SQ_W-1:0]            spread_sq_sum;
	int unsigned                held_count;
	int unsigned                write_slot;
	logic [THR_W-1:0]           entry_thr;
	logic [THR_W-1:0]           exit_thr;

	// Signals predicted for accepted price beats, oldest first.
	logic [SIG_W-1:0] pending_signals [$];
	int               mismatches = 0;

	// Idling controls of the stimulus (idle_on) and the result sink (stalls_on, stall_left).
	bit idle_on;
	bit stalls_on;
	int stall_left;

	// Directed beats. The first eight fill the window with zero spreads, so the
	// next two meet a window of zero variance: an equal spread gives no signal
	// and a positive one goes long whatever the entry threshold. The block of
	// alternating +1/-1 spreads sets up a window with mean 0 and deviation 1,
	// where a spread of +1 lands exactly on the default entry threshold (not
	// strictly above, so no signal) and a spread of 0 is a clear close.
	tick_row_t directed_rows [DIRECTED_ROWS] = '{
		'{24'h000000, 24'h000000, ROW_QUIET, SIG_NONE},
		'{PRICE_MAX, PRICE_MAX, ROW_QUIET, SIG_NONE},
		'{24'h000064, 24'h000064, ROW_QUIET, SIG_NONE},
		'{24'hAAAAAA, 24'hAAAAAA, ROW_QUIET, SIG_NONE},
		'{24'h555555, 24'h555555, ROW_QUIET, SIG_NONE},
		'{24'h800000, 24'h800000, ROW_QUIET, SIG_NONE},
		'{24'h7FFFFF, 24'h7FFFFF, ROW_QUIET, SIG_NONE},
		'{24'h000001, 24'h000001, ROW_QUIET, SIG_NONE},
		'{24'd5, 24'd5, ROW_TYPED, SIG_NONE},
		'{PRICE_MAX, 24'd0, ROW_TYPED, SIG_LONG},
		'{24'd0, PRICE_MAX, ROW_PREDICT, SIG_NONE},
		'{PRICE_MAX, PRICE_MAX, ROW_PREDICT, SIG_NONE},
		'{24'd1, 24'd0, ROW_PREDICT, SIG_NONE},
		'{24'd0, 24'd1, ROW_PREDICT, SIG_NONE},
		'{24'd2, 24'd1, ROW_PREDICT, SIG_NONE},
		'{24'd1, 24'd2, ROW_PREDICT, SIG_NONE},
		'{PRICE_MAX, PRICE_MAX - 24'd1, ROW_PREDICT, SIG_NONE},
		'{PRICE_MAX - 24'd1, PRICE_MAX, ROW_PREDICT, SIG_NONE},
		'{24'd8, 24'd7, ROW_PREDICT, SIG_NONE},
		'{24'd7, 24'd8, ROW_PREDICT, SIG_NONE},
		'{24'd101, 24'd100, ROW_TYPED, SIG_NONE},
		'{24'd42, 24'd42, ROW_TYPED, SIG_CLOSE},
		'{24'd0, 24'd1, ROW_PREDICT, SIG_NONE}
	};

	function automatic logic [SMAG_W-1:0] spread_mag(input logic signed [SPREAD_W-1:0] v);
		return SMAG_W'((v < 0) ? -v : v);
	endfunction

	// Signal for a new spread against the earlier window. With d = W*s - S and
	// V = W*Q - S*S, |z| compares with T/256 as d*d*65536 does with T*T*V, all
	// held exactly in 128 bits.
	function automatic logic [SIG_W-1:0] judge_spread(input logic signed [SPREAD_W-1:0] sp);
		logic signed [D_W-1:0] dev;
		logic [127:0] dev_mag, sum_mag, var_w, lhs;
		dev = sp * WINDOW - spread_sum;
		dev_mag = (dev < 0) ? 128'(-dev) : 128'(dev);
		sum_mag = (spread_sum < 0) ? 128'(-spread_sum) : 128'(spread_sum);
		var_w = 128'(spread_sq_sum) * WINDOW - sum_mag * sum_mag;
		lhs = (dev_mag * dev_mag) << 16;
		// A flat window behaves like an infinite z, or no z at all when d is 0.
		if (var_w == 0) begin
			if (dev > 0)
				return SIG_LONG;
			if (dev < 0)
				return SIG_SHORT;
			return SIG_NONE;
		end
		if (lhs > var_w * entry_thr * entry_thr) begin
			if (dev > 0)
				return SIG_LONG;
			if (dev < 0)
				return SIG_SHORT;
		end
		if (lhs < var_w * exit_thr * exit_thr)
			return SIG_CLOSE;
		return SIG_NONE;
	endfunction

	// Advances the predictor by one price beat; returns 1 when a signal is due.
	function automatic bit track_prices(input logic [PRICE_W-1:0] pa, input logic [PRICE_W-1:0] pb,
			output logic [SIG_W-1:0] sig);
		logic signed [SPREAD_W-1:0] sp;
		logic signed [SPREAD_W-1:0] oldest;
		logic [SMAG_W-1:0] m;
		bit fired;
		sp = $signed({1'b0, pa}) - $signed({1'b0, pb});
		fired = 1'b0;
		sig = SIG_NONE;
		if (held_count >= WINDOW) begin
			oldest = held_spreads[write_slot];
			sig = judge_spread(sp);
			fired = 1'b1;
			m = spread_mag(oldest);
			spread_sum = spread_sum - oldest;
			spread_sq_sum = spread_sq_sum - SQ_W'(m) * m;
		end else begin
			held_count++;
		end
		held_spreads[write_slot] = sp;
		m = spread_mag(sp);
		spread_sum = spread_sum + sp;
		spread_sq_sum = spread_sq_sum + SQ_W'(m) * m;
		write_slot = (write_slot + 1) % WINDOW;
		return fired;
	endfunction

	// Offers one price beat, waits for it to be taken and records what it owes.
	task automatic send_tick(input logic [PRICE_W-1:0] pa, input logic [PRICE_W-1:0] pb,
			input row_kind_t kind = ROW_PREDICT, input logic [SIG_W-1:0] typed = SIG_NONE);
		logic [SIG_W-1:0] sig;
		bit fired;
		@(negedge clk);
		tick_if.valid = 1'b1;
		tick_if.price_a = pa;
		tick_if.price_b = pb;
		do @(posedge clk); while (!tick_if.ready);
		fired = track_prices(pa, pb, sig);
		if (kind == ROW_TYPED)
			pending_signals = {pending_signals, typed};
		else if (kind == ROW_PREDICT && fired)
			pending_signals = {pending_signals, sig};
	endtask

	// Source idling. Part of the gaps end when the block hands out its signal,
	// so that the next beat meets the block at a late point of its work.
	task automatic maybe_pause();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			tick_if.valid = 1'b0;
			if ($urandom_range(0, 2) == 0)
				while (pending_signals.size() != 0) @(posedge clk);
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
	endtask

	// Drops the price channel and lets the block finish all it holds.
	task automatic settle_block();
		@(negedge clk);
		tick_if.valid = 1'b0;
		while (pending_signals.size() != 0) @(posedge clk);
		repeat (BEAT_CYCLES + 16) @(posedge clk);
	endtask

	task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
		logic [CFG_DATA_W-1:0] got;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		if (got !== CFG_DATA_W'(value)) begin
			$display("%0t: register %0d read: expected %0d, got %0d", $time, idx, value, got);
			mismatches++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Upper data bits are random; the register keeps only its 16 bits.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {THR_W'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_ENTRY)
			entry_thr = value;
		else
			exit_thr = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		check_reg(idx, value);
	endtask

	function automatic longint rand_offset(input longint amp);
		return longint'($urandom_range(0, int'(2 * amp))) - amp;
	endfunction

	function automatic longint clamp_spread(input longint s);
		if (s > SPREAD_PEAK)
			return SPREAD_PEAK;
		if (s < -SPREAD_PEAK)
			return -SPREAD_PEAK;
		return s;
	endfunction

	// Picks a price pair with the given spread, now and then pinned to a rail.
	function automatic void split_spread(input longint s, output logic [PRICE_W-1:0] pa,
			output logic [PRICE_W-1:0] pb);
		longint low_leg, span;
		span = (s < 0) ? -s : s;
		case ($urandom_range(0, 9))
			0: low_leg = 0;
			1: low_leg = SPREAD_PEAK - span;
			default: low_leg = longint'($urandom_range(0, int'(SPREAD_PEAK - span)));
		endcase
		if (s >= 0) begin
			pb = PRICE_W'(low_leg);
			pa = PRICE_W'(low_leg + s);
		end else begin
			pa = PRICE_W'(low_leg);
			pb = PRICE_W'(low_leg - s);
		end
	endfunction

	// Result sink. Ready drops in random stall bursts and changes on the falling
	// edge only.
	initial begin
		result_if.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				result_if.ready = 1'b0;
				stall_left--;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				result_if.ready = 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				result_if.ready = 1'b1;
			end
		end
	end

	// Every signal beat taken must match the oldest prediction.
	always @(posedge clk) begin
		logic [SIG_W-1:0] want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_signals.size() == 0) begin
				$display("%0t: signal beat with nothing expected: expected none, got %0d",
					$time, result_if.signal);
				mismatches++;
			end else begin
				want = pending_signals.pop_front();
				if (result_if.signal !== want) begin
					$display("%0t: signal mismatch: expected %0d, got %0d",
						$time, want, result_if.signal);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [PRICE_W-1:0] pa, pb;
		logic [THR_W-1:0] new_entry, new_exit;
		longint base, amp, sp;
		spread_shape_t shape;
		int seg_len, remaining, sent;

		tick_if.valid = 1'b0;
		tick_if.price_a = '0;
		tick_if.price_b = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b1;
		stalls_on = 1'b1;
		arst_n = 1'b0;

		// Predictor starts from the reset state of the block.
		foreach (held_spreads[i])
			held_spreads[i] = '0;
		spread_sum = '0;
		spread_sq_sum = '0;
		held_count = 0;
		write_slot = 0;
		entry_thr = ENTRY_RESET;
		exit_thr = EXIT_RESET;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Thresholds must come out of reset at their defaults.
		check_reg(REG_ENTRY, ENTRY_RESET);
		check_reg(REG_EXIT, EXIT_RESET);

		foreach (directed_rows[i]) begin
			maybe_pause();
			send_tick(directed_rows[i].price_a, directed_rows[i].price_b,
				directed_rows[i].kind, directed_rows[i].signal);
		end

		// Random phases. The first four pin both thresholds to their rails,
		// which covers a zero exit (no close ever) and a zero entry (any
		// nonzero deviation opens); the last goes back to the reset values.
		remaining = PHASES * TICKS_PER_PHASE;
		for (int ph = 0; ph < PHASES; ph++) begin
			settle_block();
			case (ph)
				0: begin new_entry = '0; new_exit = '0; end
				1: begin new_entry = '1; new_exit = '1; end
				2: begin new_entry = '1; new_exit = '0; end
				3: begin new_entry = '0; new_exit = '1; end
				PHASES - 1: begin new_entry = ENTRY_RESET; new_exit = EXIT_RESET; end
				default: begin
					new_entry = THR_W'($urandom_range(64, 768));
					new_exit = THR_W'($urandom_range(0, new_entry));
				end
			endcase
			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_ENTRY, new_entry);
				write_reg(REG_EXIT, new_exit);
			end else begin
				write_reg(REG_EXIT, new_exit);
				write_reg(REG_ENTRY, new_entry);
			end

			sent = 0;
			while (sent < TICKS_PER_PHASE) begin
				// Each segment is a run of spreads of one character around a
				// base: flat runs reach the zero-variance cases, jitter gives
				// z-scores near the thresholds, swings and raw prices reach
				// the extremes of the arithmetic.
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4: shape = SHAPE_FLAT;
					5, 6, 7, 8, 9, 10, 11, 12: shape = SHAPE_JITTER;
					13, 14, 15, 16: shape = SHAPE_SWING;
					default: shape = SHAPE_RAW;
				endcase
				seg_len = $urandom_range(10, 40);
				if ($urandom_range(0, 2) == 0)
					base = rand_offset(1000);
				else
					base = rand_offset(SPREAD_PEAK);
				if (shape == SHAPE_SWING)
					amp = longint'(1) << $urandom_range(13, 23);
				else
					amp = longint'(1) << $urandom_range(0, 12);
				idle_on = ($urandom_range(0, 3) != 0);
				stalls_on = ($urandom_range(0, 3) != 0);

				for (int k = 0; k < seg_len && sent < TICKS_PER_PHASE; k++) begin
					// The tail of the run is free of idling on both sides.
					if (remaining <= CALM_TICKS) begin
						idle_on = 1'b0;
						stalls_on = 1'b0;
					end
					case (shape)
						SHAPE_FLAT: begin
							sp = base;
							if ($urandom_range(0, 5) == 0)
								sp = base + rand_offset(amp);
						end
						SHAPE_JITTER: begin
							sp = base + rand_offset(amp);
							if ($urandom_range(0, 9) == 0)
								sp = base + rand_offset(8 * amp);
						end
						default: sp = base + rand_offset(amp);
					endcase
					if (shape == SHAPE_RAW) begin
						pa = ($urandom_range(0, 3) == 0) ? {PRICE_W{$urandom_range(0, 1) == 1}}
							: PRICE_W'($urandom);
						pb = ($urandom_range(0, 3) == 0) ? {PRICE_W{$urandom_range(0, 1) == 1}}
							: PRICE_W'($urandom);
					end else begin
						split_spread(clamp_spread(sp), pa, pb);
					end
					maybe_pause();
					send_tick(pa, pb);
					sent++;
					remaining--;
				end
			end
		end

		settle_block();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Guard against a hung handshake: far beyond the slowest correct run.
	initial begin
		#15_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rzps_pkg.sv
hdl/rzps_if.sv
hdl/rzps_ram.sv
hdl/rzps_mul.sv
hdl/rzps_cfg.sv
hdl/rzps_core.sv
hdl/rolling_zscore_pair_signal.sv
verif/testbench.sv
